// ----- rtl/core/rptg_pkg.sv -----
package rptg_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int CORDIC_STAGES_MAX = 24;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] REG_RADAR_WIDTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_SECOND = 1'd1;

  localparam logic [7:0] TYPE_BEACON = 8'd5;
  localparam logic [7:0] TYPE_INVISIBLE = 8'd10;

  localparam logic [15:0] THIRD_TURN = 16'd21845;
  localparam logic signed [33:0] CORDIC_START = 34'sd652032874;

  // quotient width for age<<17 / (3*tps): 49-bit dividend
  localparam int DIV_N = 49;
  localparam int DIV_D = 12;
  localparam int ALPHA_N = 40;
  localparam int ALPHA_D = 32;

  typedef struct packed {
    logic [7:0]         event_type;
    logic [31:0]        create_tick;
    logic [31:0]        fade_tick;
    logic [31:0]        die_tick;
    logic [31:0]        current_frame;
    logic signed [15:0] center_x;
    logic signed [15:0] center_y;
  } in_item_t;

  typedef struct packed {
    logic               visible;
    logic [10:0]        radius;
    logic [15:0]        rotation_phase;
    logic [31:0]        start_color;
    logic [31:0]        end_color;
    logic signed [15:0] vertex0_x;
    logic signed [15:0] vertex0_y;
    logic signed [15:0] vertex1_x;
    logic signed [15:0] vertex1_y;
    logic signed [15:0] vertex2_x;
    logic signed [15:0] vertex2_y;
  } out_item_t;

  function automatic logic [33:0] atan_val(input int i);
    logic [33:0] t;
    unique case (i)
      0: t = 34'd536870912;  1: t = 34'd316933406;  2: t = 34'd167458907;
      3: t = 34'd85004756;   4: t = 34'd42667331;   5: t = 34'd21354465;
      6: t = 34'd10680862;   7: t = 34'd5340245;    8: t = 34'd2670675;
      9: t = 34'd1335343;    10: t = 34'd667544;    11: t = 34'd333772;
      12: t = 34'd166886;    13: t = 34'd83443;     14: t = 34'd41722;
      15: t = 34'd20861;     16: t = 34'd10430;     17: t = 34'd5215;
      18: t = 34'd2608;      19: t = 34'd1304;      20: t = 34'd652;
      21: t = 34'd326;       22: t = 34'd163;       23: t = 34'd81;
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic logic [47:0] color_pair(input logic [7:0] t);
    logic [47:0] c;
    unique case (t)
      8'd1: c = {24'h8080ff, 24'h80ffff};
      8'd2: c = {24'h800040, 24'hffb9dc};
      8'd3: c = {24'hff0000, 24'hff8080};
      8'd4, 8'd5: c = {24'hffff00, 24'hffff80};
      8'd6: c = {24'h00ffff, 24'h80ffff};
      8'd7: c = {24'hffffff, 24'hffffff};
      8'd8, 8'd9: c = {24'h00ff00, 24'h008000};
      default: c = {24'hffffff, 24'hffffff};
    endcase
    return c;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
    if (v > 20'sd32767) return 16'sh7fff;
    if (v < -20'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

endpackage

// ----- rtl/core/rptg_stream_if.sv -----
interface rptg_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/rptg_cordic.sv -----
// pipelined cordic, one rotation per stage, with a shared stall enable
module rptg_cordic #(
  parameter int STAGES = rptg_pkg::CORDIC_STAGES_DEF,
  parameter int TAG_W  = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic [15:0]         phase,
  input  logic [TAG_W-1:0]    tag_in,
  output logic signed [15:0]  cos_q15,
  output logic signed [15:0]  sin_q15,
  output logic [TAG_W-1:0]    tag_out
);

  logic signed [33:0] x_r [STAGES+1];
  logic signed [33:0] y_r [STAGES+1];
  logic signed [33:0] z_r [STAGES+1];
  logic               neg_r [STAGES+1];
  logic [TAG_W-1:0]   tag_r [STAGES+1];

  logic signed [33:0] z0;
  logic signed [33:0] zf;
  logic               negf;

  always_comb begin
    z0 = {{2{phase[15]}}, phase, 16'd0};
    negf = 1'b0;
    zf = z0;
    if (z0 > 34'sh040000000) begin
      zf = z0 - 34'sh080000000;
      negf = 1'b1;
    end else if (z0 < -34'sh040000000) begin
      zf = z0 + 34'sh080000000;
      negf = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= rptg_pkg::CORDIC_START;
      y_r[0] <= '0;
      z_r[0] <= zf;
      neg_r[0] <= negf;
      tag_r[0] <= tag_in;
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        if (!z_r[i][33]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - $signed(rptg_pkg::atan_val(i));
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + $signed(rptg_pkg::atan_val(i));
        end
        neg_r[i+1] <= neg_r[i];
        tag_r[i+1] <= tag_r[i];
      end
    end
  end

  logic signed [34:0] xe, ye, xr, yr;
  always_comb begin
    xe = neg_r[STAGES] ? -35'(x_r[STAGES]) : 35'(x_r[STAGES]);
    ye = neg_r[STAGES] ? -35'(y_r[STAGES]) : 35'(y_r[STAGES]);
    xr = (xe + 35'sd16384) >>> 15;
    yr = (ye + 35'sd16384) >>> 15;
    cos_q15 = (xr > 35'sd32767) ? 16'sh7fff : (xr < -35'sd32768) ? 16'sh8000 : xr[15:0];
    sin_q15 = (yr > 35'sd32767) ? 16'sh7fff : (yr < -35'sd32768) ? 16'sh8000 : yr[15:0];
    tag_out = tag_r[STAGES];
  end

endmodule

// ----- rtl/core/rptg_div.sv -----
// pipelined restoring divider, one quotient bit per stage
module rptg_div #(
  parameter int N = 8,
  parameter int D = 8,
  parameter int TAG_W = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [N-1:0]     num,
  input  logic [D-1:0]     den,
  input  logic [TAG_W-1:0] tag_in,
  output logic [N-1:0]     quo,
  output logic [TAG_W-1:0] tag_out
);

  logic [D:0]       rem_r [N+1];
  logic [N-1:0]     num_r [N+1];
  logic [N-1:0]     q_r   [N+1];
  logic [D-1:0]     den_r [N+1];
  logic [TAG_W-1:0] tag_r [N+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= '0;
      num_r[0] <= num;
      q_r[0] <= '0;
      den_r[0] <= den;
      tag_r[0] <= tag_in;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_bit
    logic [D+1:0] trial;
    assign trial = {rem_r[i], num_r[i][N-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        if (trial >= {2'b00, den_r[i]}) begin
          rem_r[i+1] <= (D+1)'(trial - {2'b00, den_r[i]});
          q_r[i+1] <= {q_r[i][N-2:0], 1'b1};
        end else begin
          rem_r[i+1] <= trial[D:0];
          q_r[i+1] <= {q_r[i][N-2:0], 1'b0};
        end
        num_r[i+1] <= num_r[i] << 1;
        den_r[i+1] <= den_r[i];
        tag_r[i+1] <= tag_r[i];
      end
    end
  end

  assign quo = q_r[N];
  assign tag_out = tag_r[N];

endmodule

// ----- rtl/core/radar_ping_triangle_generator.sv -----
// Radar ping triangle generator.
// Input channel in_*: one radar event per transfer (type, create/fade/die
// ticks, current frame, center). Output channel out_*: one triangle result
// per event, in order. Configuration: cfg_we/cfg_index/cfg_wdata write
// radar_width (index 0) and ticks_per_second (index 1); write only when idle.
// Throughput: one event per cycle while in_ready is high (no output stall).
// The latency from an input transfer to out valid is set by the pipelined
// progress divider (one quotient bit per stage) followed by the CORDIC
// pipeline and the radius multiply and vertex add.
// The alpha divider runs in parallel inside the progress divider span.
// The whole pipeline advances together: when the receiver stalls, a
// two-entry skid buffer at the output absorbs in-flight items and in_ready
// drops, so nothing is lost or repeated.
// Reset (synchronous, rst_n low) clears all valid bits and loads
// radar_width = 256 and ticks_per_second = 30.
module radar_ping_triangle_generator #(
  parameter int CORDIC_STAGES = rptg_pkg::CORDIC_STAGES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  rptg_stream_if.sink                       in_ch,
  rptg_stream_if.source                     out_ch,
  input  logic                              cfg_we,
  input  logic [rptg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rptg_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int LAT = rptg_pkg::DIV_N + 2 + CORDIC_STAGES + 4;

  logic [11:0] radar_width_r;
  logic [9:0]  tps_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radar_width_r <= 12'd256;
      tps_r <= 10'd30;
    end else if (cfg_we) begin
      if (cfg_index == rptg_pkg::REG_RADAR_WIDTH) radar_width_r <= cfg_wdata[11:0];
      else if (cfg_index == rptg_pkg::REG_TICKS_PER_SECOND) tps_r <= cfg_wdata[9:0];
    end
  end

  // skid fifo of depth 2; the pipeline moves whenever the fifo cannot overflow
  logic en;
  logic [LAT-1:0] vld_r;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  rptg_pkg::out_item_t fifo_r [2];
  logic rd_ptr_r, wr_ptr_r;
  rptg_pkg::out_item_t res;
  logic res_v;

  // items in flight that can still land: allow advance when fifo has room
  assign en = (cnt_r == 2'd0) || (cnt_r == 2'd1 && !vld_r[LAT-1]) ||
              (out_ch.ready && (cnt_r != 2'd2 || !vld_r[LAT-1])) ||
              !vld_r[LAT-1];
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[LAT-2:0], in_ch.valid};
  end

  assign res_v = en && vld_r[LAT-1];

  always_comb begin
    cnt_nxt = cnt_r;
    if (res_v) cnt_nxt = cnt_nxt + 2'd1;
    if (out_ch.valid && out_ch.ready) cnt_nxt = cnt_nxt - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_ptr_r <= 1'b0;
      wr_ptr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (res_v) wr_ptr_r <= !wr_ptr_r;
      if (out_ch.valid && out_ch.ready) rd_ptr_r <= !rd_ptr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (res_v) fifo_r[wr_ptr_r] <= res;
  end

  assign out_ch.valid = (cnt_r != 2'd0);
  assign out_ch.data = fifo_r[rd_ptr_r];

  // ---- stage 0: register input and derive age, suppress, alpha operands
  rptg_pkg::in_item_t in_d;
  assign in_d = in_ch.data;

  typedef struct packed {
    logic               supp;
    logic               beacon;
    logic [7:0]         etype;
    logic               fade_on;
    logic               alpha_zero;
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic [11:0]        rw;
  } side_t;

  side_t s0_nxt;
  logic [rptg_pkg::DIV_N-1:0] pnum;
  logic [rptg_pkg::ALPHA_N-1:0] anum;
  logic [31:0] age;

  always_comb begin
    age = (in_d.current_frame >= in_d.create_tick) ?
          in_d.current_frame - in_d.create_tick : 32'd0;
    pnum = {age, 17'd0};
    anum = {in_d.die_tick - in_d.current_frame, 8'd0} -
           {8'd0, in_d.die_tick - in_d.current_frame};
    s0_nxt.supp = (in_d.event_type == rptg_pkg::TYPE_INVISIBLE) ||
                  (in_d.current_frame > in_d.die_tick) ||
                  (radar_width_r == 12'd0) || (tps_r == 10'd0);
    s0_nxt.beacon = (in_d.event_type == rptg_pkg::TYPE_BEACON);
    s0_nxt.etype = in_d.event_type;
    s0_nxt.fade_on = (in_d.current_frame > in_d.fade_tick);
    s0_nxt.alpha_zero = (in_d.die_tick <= in_d.fade_tick);
    s0_nxt.cx = in_d.center_x;
    s0_nxt.cy = in_d.center_y;
    s0_nxt.rw = radar_width_r;
  end

  localparam int ATAG = 1;
  logic [rptg_pkg::DIV_N-1:0] p_q;
  side_t s1;
  logic [rptg_pkg::ALPHA_N-1:0] a_q;
  logic a_tag_unused;

  rptg_div #(.N(rptg_pkg::DIV_N), .D(rptg_pkg::DIV_D), .TAG_W($bits(side_t))) u_pdiv (
    .clk, .en, .num(pnum), .den(12'(3 * tps_r)), .tag_in(s0_nxt),
    .quo(p_q), .tag_out(s1)
  );

  // alpha divider padded to the same depth via a quotient delay line
  logic [rptg_pkg::ALPHA_N-1:0] a_q_d [rptg_pkg::DIV_N-rptg_pkg::ALPHA_N+1];
  rptg_div #(.N(rptg_pkg::ALPHA_N), .D(rptg_pkg::ALPHA_D), .TAG_W(ATAG)) u_adiv (
    .clk, .en, .num(anum), .den(in_d.die_tick - in_d.fade_tick), .tag_in(1'b0),
    .quo(a_q), .tag_out(a_tag_unused)
  );
  assign a_q_d[0] = a_q;
  for (genvar k = 0; k < rptg_pkg::DIV_N - rptg_pkg::ALPHA_N; k++) begin : g_ad
    always_ff @(posedge clk) if (en) a_q_d[k+1] <= a_q_d[k];
  end

  // ---- stage A: 1-p, p range flag, phase, alpha
  typedef struct packed {
    side_t       sd;
    logic        p_big;
    logic [16:0] one_m_p;
    logic [15:0] phase;
    logic [7:0]  alpha;
  } sa_t;
  sa_t sa_r;
  logic [7:0] alpha_c;
  logic [rptg_pkg::ALPHA_N-1:0] aq;

  always_comb begin
    aq = a_q_d[rptg_pkg::DIV_N-rptg_pkg::ALPHA_N];
    if (!s1.fade_on) alpha_c = 8'd255;
    else if (s1.alpha_zero) alpha_c = 8'd0;
    else if (aq > 40'd255) alpha_c = 8'd255;
    else alpha_c = aq[7:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sa_r.sd <= s1;
      sa_r.p_big <= (p_q >= 49'd65536);
      sa_r.one_m_p <= 17'(17'd65536 - p_q[16:0]);
      sa_r.phase <= s1.beacon ? p_q[15:0] : 16'(16'd0 - p_q[15:0]);
      sa_r.alpha <= alpha_c;
    end
  end

  // ---- stage B: multiply width by (1-p)
  typedef struct packed {
    side_t       sd;
    logic        p_big;
    logic [28:0] prod;
    logic [15:0] phase;
    logic [7:0]  alpha;
  } sb_t;
  sb_t sb_r;
  always_ff @(posedge clk) begin
    if (en) begin
      sb_r.sd <= sa_r.sd;
      sb_r.p_big <= sa_r.p_big;
      sb_r.prod <= 29'(sa_r.sd.rw) * 29'(sa_r.one_m_p);
      sb_r.phase <= sa_r.phase;
      sb_r.alpha <= sa_r.alpha;
    end
  end

  // radius: beacon divides by 655360 = 10 * 65536
  logic [12:0] hi16;
  logic [10:0] rad_c;
  logic [12:0] rad_w;
  always_comb begin
    hi16 = sb_r.prod[28:16];
    if (sb_r.p_big) rad_w = 13'd0;
    else if (sb_r.sd.beacon) rad_w = 13'((26'(hi16) * 26'd6554) >> 16);
    else rad_w = {1'b0, sb_r.prod[28:17]};
    if (!sb_r.p_big && sb_r.sd.beacon && 13'(rad_w * 13'd10) > hi16) rad_w = rad_w - 13'd1;
    rad_c = (rad_w < 13'd6) ? 11'd6 : rad_w[10:0];
  end

  typedef struct packed {
    side_t       sd;
    logic [10:0] rad;
    logic [15:0] phase;
    logic [7:0]  alpha;
  } sc_t;
  sc_t sc_in, sc0, sc1, sc2;
  assign sc_in = '{sd: sb_r.sd, rad: rad_c, phase: sb_r.phase, alpha: sb_r.alpha};

  logic signed [15:0] c0, s0v, c1, s1v, c2, s2v;
  rptg_cordic #(.STAGES(CORDIC_STAGES), .TAG_W($bits(sc_t))) u_c0 (
    .clk, .rst_n, .en, .phase(sb_r.phase), .tag_in(sc_in),
    .cos_q15(c0), .sin_q15(s0v), .tag_out(sc0)
  );
  rptg_cordic #(.STAGES(CORDIC_STAGES), .TAG_W($bits(sc_t))) u_c1 (
    .clk, .rst_n, .en, .phase(16'(sb_r.phase + rptg_pkg::THIRD_TURN)), .tag_in(sc_in),
    .cos_q15(c1), .sin_q15(s1v), .tag_out(sc1)
  );
  rptg_cordic #(.STAGES(CORDIC_STAGES), .TAG_W($bits(sc_t))) u_c2 (
    .clk, .rst_n, .en, .phase(16'(sb_r.phase - rptg_pkg::THIRD_TURN)), .tag_in(sc_in),
    .cos_q15(c2), .sin_q15(s2v), .tag_out(sc2)
  );

  // ---- stage D: register trig, then multiply by radius
  logic signed [15:0] trig_r [6];
  sc_t sd_r;
  logic signed [27:0] mul_r [6];
  sc_t se_r;
  always_ff @(posedge clk) begin
    if (en) begin
      trig_r[0] <= c0; trig_r[1] <= s0v;
      trig_r[2] <= c1; trig_r[3] <= s1v;
      trig_r[4] <= c2; trig_r[5] <= s2v;
      sd_r <= sc0;
      for (int k = 0; k < 6; k++)
        mul_r[k] <= 28'(trig_r[k]) * $signed({17'd0, sd_r.rad});
      se_r <= sd_r;
    end
  end

  logic signed [15:0] off [6];
  logic signed [15:0] vtx [6];
  logic [47:0] cp;
  always_comb begin
    for (int k = 0; k < 6; k++) begin
      off[k] = 16'((mul_r[k] + 28'sd1024) >>> 11);
      vtx[k] = rptg_pkg::sat16(20'(k[0] ? se_r.sd.cy : se_r.sd.cx) + 20'(off[k]));
    end
    cp = rptg_pkg::color_pair(se_r.sd.etype);
    res = '0;
    if (!se_r.sd.supp) begin
      res.visible = 1'b1;
      res.radius = se_r.rad;
      res.rotation_phase = se_r.phase;
      res.start_color = {se_r.alpha, cp[47:24]};
      res.end_color = {se_r.alpha, cp[23:0]};
      res.vertex0_x = vtx[0]; res.vertex0_y = vtx[1];
      res.vertex1_x = vtx[2]; res.vertex1_y = vtx[3];
      res.vertex2_x = vtx[4]; res.vertex2_y = vtx[5];
    end
  end

endmodule

// ----- sim/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_STAGES = rptg_pkg::CORDIC_STAGES_DEF;
  localparam int PIPE_DEPTH = rptg_pkg::DIV_N + NUM_STAGES + 8;
  localparam int STALL_LIMIT = 5000;
  localparam int ITEMS_PER_PHASE = 190;

  typedef struct {
    rptg_pkg::in_item_t ev;
    bit       known;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [rptg_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [rptg_pkg::CFG_DATA_W-1:0] cfg_wdata;

  rptg_stream_if #(.payload_t(rptg_pkg::in_item_t)) in_if ();
  rptg_stream_if #(.payload_t(rptg_pkg::out_item_t)) out_if ();

  radar_ping_triangle_generator dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_if), .out_ch(out_if),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  longint unsigned width_q = 256;
  longint unsigned tps_q = 30;
  rptg_pkg::out_item_t triangle_q[$];
  bit cur_known;
  bit in_taken;
  int errors = 0;
  int quiet_cycles = 0;

  longint atan_tbl[24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10680862, 5340245, 2670675, 1335343, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81
  };

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic longint sat_q124(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic void sin_cos(input logic [15:0] ang, output longint c,
                                  output longint s);
    longint z, x, y, nx;
    bit neg;
    z = longint'(ang) << 16;
    x = 652032874;
    y = 0;
    neg = 0;
    if (z >= 64'sh8000_0000) z -= 64'sh1_0000_0000;
    // fold into a half turn around zero
    if (z > 64'sh4000_0000) begin
      z -= 64'sh8000_0000;
      neg = 1;
    end else if (z < -64'sh4000_0000) begin
      z += 64'sh8000_0000;
      neg = 1;
    end
    for (int i = 0; i < NUM_STAGES; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= atan_tbl[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += atan_tbl[i];
      end
      x = nx;
    end
    if (neg) begin
      x = -x;
      y = -y;
    end
    c = sat_q124((x + 16384) >>> 15);
    s = sat_q124((y + 16384) >>> 15);
  endfunction

  function automatic rptg_pkg::out_item_t predict_ping(rptg_pkg::in_item_t ev);
    rptg_pkg::out_item_t r;
    longint unsigned age, p, rad, phase, alpha;
    logic [23:0] prim, sec;
    longint c, s, vx, vy;
    logic [15:0] ang;
    bit beacon;
    r = '0;
    if (ev.event_type == rptg_pkg::TYPE_INVISIBLE || ev.current_frame > ev.die_tick ||
        width_q == 0 || tps_q == 0) return r;
    beacon = (ev.event_type == rptg_pkg::TYPE_BEACON);
    age = (ev.current_frame >= ev.create_tick) ? ev.current_frame - ev.create_tick : 0;
    p = (age << 17) / (3 * tps_q);
    rad = 0;
    if (p < 65536) begin
      if (beacon) rad = width_q * (65536 - p) / 655360;
      else rad = (width_q * (65536 - p)) >> 17;
    end
    if (rad < 6) rad = 6;
    phase = (beacon ? p : 64'd0 - p) & 16'hffff;
    alpha = 255;
    if (ev.current_frame > ev.fade_tick) begin
      if (ev.die_tick <= ev.fade_tick) alpha = 0;
      else begin
        alpha = longint'(ev.die_tick - ev.current_frame) * 255 /
                longint'(ev.die_tick - ev.fade_tick);
        if (alpha > 255) alpha = 255;
      end
    end
    case (ev.event_type)
      8'd1: {prim, sec} = {24'h8080ff, 24'h80ffff};
      8'd2: {prim, sec} = {24'h800040, 24'hffb9dc};
      8'd3: {prim, sec} = {24'hff0000, 24'hff8080};
      8'd4, 8'd5: {prim, sec} = {24'hffff00, 24'hffff80};
      8'd6: {prim, sec} = {24'h00ffff, 24'h80ffff};
      8'd8, 8'd9: {prim, sec} = {24'h00ff00, 24'h008000};
      default: {prim, sec} = {24'hffffff, 24'hffffff};
    endcase
    r.visible = 1'b1;
    r.radius = rad[10:0];
    r.rotation_phase = phase[15:0];
    r.start_color = {alpha[7:0], prim};
    r.end_color = {alpha[7:0], sec};
    for (int k = 0; k < 3; k++) begin
      ang = phase[15:0];
      if (k == 1) ang = ang + rptg_pkg::THIRD_TURN;
      if (k == 2) ang = ang - rptg_pkg::THIRD_TURN;
      sin_cos(ang, c, s);
      vx = sat_q124(longint'(ev.center_x) + ((c * longint'(rad) + 1024) >>> 11));
      vy = sat_q124(longint'(ev.center_y) + ((s * longint'(rad) + 1024) >>> 11));
      case (k)
        0: begin r.vertex0_x = vx[15:0]; r.vertex0_y = vy[15:0]; end
        1: begin r.vertex1_x = vx[15:0]; r.vertex1_y = vy[15:0]; end
        default: begin r.vertex2_x = vx[15:0]; r.vertex2_y = vy[15:0]; end
      endcase
    end
    return r;
  endfunction

  task automatic check_field(string name, longint unsigned e, longint unsigned a);
    if (e != a) begin
      $display("%0t mismatch %s: expected %0h actual %0h", $realtime, name, e, a);
      errors++;
    end
  endtask

  // transfer monitors and scoreboard
  always @(posedge clk) begin
    rptg_pkg::out_item_t e, a;
    in_taken <= in_if.valid && in_if.ready;
    if (in_if.valid && in_if.ready)
      triangle_q.push_back(cur_known ? rptg_pkg::out_item_t'('0) : predict_ping(in_if.data));
    if (out_if.valid && out_if.ready) begin
      a = out_if.data;
      if (triangle_q.size() == 0) begin
        $display("%0t unexpected result %0h", $realtime, a);
        errors++;
      end else begin
        e = triangle_q.pop_front();
        check_field("visible", e.visible, a.visible);
        check_field("radius", e.radius, a.radius);
        check_field("rotation_phase", e.rotation_phase, a.rotation_phase);
        check_field("start_color", e.start_color, a.start_color);
        check_field("end_color", e.end_color, a.end_color);
        check_field("vertex0_x", e.vertex0_x, a.vertex0_x);
        check_field("vertex0_y", e.vertex0_y, a.vertex0_y);
        check_field("vertex1_x", e.vertex1_x, a.vertex1_x);
        check_field("vertex1_y", e.vertex1_y, a.vertex1_y);
        check_field("vertex2_x", e.vertex2_x, a.vertex2_x);
        check_field("vertex2_y", e.vertex2_y, a.vertex2_y);
      end
    end
  end

  // watchdog on transfer activity
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver stall pattern
  initial begin
    int hold;
    int mode;
    hold = 0;
    mode = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) hold--;
      else begin
        if ($urandom_range(0, 15) == 0) mode = $urandom_range(0, 2);
        case (mode)
          0: begin out_if.ready <= 1'b1; hold = $urandom_range(0, 30); end
          1: begin out_if.ready <= $urandom_range(0, 1); hold = 0; end
          default: begin
            out_if.ready <= ~out_if.ready;
            hold = $urandom_range(1, 20);
          end
        endcase
      end
    end
  end

  int burst_left = 0;

  task automatic send_event(rptg_pkg::in_item_t ev, bit known);
    if (burst_left == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_if.valid <= 1'b1;
    in_if.data <= ev;
    cur_known <= known;
    do @(negedge clk); while (!in_taken);
  endtask

  task automatic write_reg(logic [rptg_pkg::CFG_IDX_W-1:0] idx, longint unsigned val);
    in_if.valid <= 1'b0;
    burst_left = 0;
    wait (triangle_q.size() == 0);
    @(negedge clk);
    repeat (PIPE_DEPTH + 4) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[rptg_pkg::CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == rptg_pkg::REG_RADAR_WIDTH) width_q = val & 12'hfff;
    else tps_q = val & 10'h3ff;
  endtask

  function automatic rptg_pkg::in_item_t random_event();
    rptg_pkg::in_item_t ev;
    longint unsigned span;
    ev.event_type = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 11));
    ev.center_x = 16'($urandom);
    ev.center_y = 16'($urandom);
    if ($urandom_range(0, 9) == 0) ev.center_x = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    if ($urandom_range(0, 9) == 0) ev.center_y = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    if ($urandom_range(0, 4) == 0) begin
      // noise: ticks unrelated to each other
      ev.create_tick = $urandom;
      ev.fade_tick = $urandom;
      ev.die_tick = $urandom;
      ev.current_frame = $urandom;
    end else begin
      span = (tps_q == 0) ? 100 : 3 * tps_q;
      ev.create_tick = $urandom;
      ev.current_frame = ev.create_tick + 32'($urandom_range(0, 32'(span)));
      if ($urandom_range(0, 15) == 0) ev.current_frame = ev.create_tick - 32'($urandom_range(1, 50));
      ev.die_tick = ev.current_frame + 32'($urandom_range(0, 300));
      ev.fade_tick = ev.die_tick - 32'($urandom_range(0, 400));
      if ($urandom_range(0, 15) == 0) ev.die_tick = ev.current_frame - 32'($urandom_range(1, 5));
    end
    return ev;
  endfunction

  stim_row_t directed[] = '{
    '{'{rptg_pkg::TYPE_INVISIBLE, 32'd0, 32'd10, 32'd20, 32'd5, 16'sd0, 16'sd0}, 1'b1},
    '{'{8'd1, 32'd0, 32'd10, 32'd20, 32'd21, 16'sd0, 16'sd0}, 1'b1},
    '{'{8'd1, 32'd100, 32'd200, 32'd300, 32'd100, 16'sd0, 16'sd0}, 1'b0},
    '{'{8'd2, 32'd100, 32'd200, 32'd300, 32'd110, 16'sh7fff, 16'sh7fff}, 1'b0},
    '{'{8'd3, 32'd100, 32'd200, 32'd300, 32'd120, 16'sh8000, 16'sh8000}, 1'b0},
    '{'{8'd4, 32'd0, 32'd40, 32'd80, 32'd45, 16'sd160, -16'sd160}, 1'b0},
    '{'{rptg_pkg::TYPE_BEACON, 32'd0, 32'd40, 32'd80, 32'd0, 16'sd0, 16'sd0}, 1'b0},
    '{'{rptg_pkg::TYPE_BEACON, 32'd0, 32'd40, 32'd80, 32'd45, 16'sd0, 16'sd0}, 1'b0},
    '{'{rptg_pkg::TYPE_BEACON, 32'd0, 32'd40, 32'd80, 32'd60, 16'sh7fff, 16'sh8000}, 1'b0},
    '{'{8'd6, 32'd50, 32'd60, 32'd70, 32'd10, 16'sd0, 16'sd0}, 1'b0},
    '{'{8'd7, 32'd0, 32'd50, 32'd50, 32'd50, 16'sd0, 16'sd0}, 1'b0},
    '{'{8'd8, 32'd0, 32'd30, 32'd20, 32'd20, 16'sd0, 16'sd0}, 1'b0},
    '{'{8'd9, 32'd0, 32'd30, 32'd40, 32'd35, 16'sd0, 16'sd0}, 1'b0},
    '{'{8'd0, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
        16'sd0, 16'sd0}, 1'b0},
    '{'{8'd255, 32'd0, 32'd0, 32'hffff_ffff, 32'hffff_fffe, 16'sd1, -16'sd1}, 1'b0},
    '{'{8'd11, 32'd0, 32'd0, 32'd0, 32'd0, 16'sd0, 16'sd0}, 1'b0},
    '{'{rptg_pkg::TYPE_INVISIBLE, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'd0,
        16'sh7fff, 16'sh7fff}, 1'b1}
  };

  longint unsigned phase_cfg[7][2] = '{
    '{4095, 1000}, '{1, 1}, '{0, 30}, '{256, 0}, '{640, 60}, '{4095, 1}, '{1, 1000}
  };

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    cur_known = 1'b0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (directed[i]) send_event(directed[i].ev, directed[i].known);
    for (int ph = 0; ph < 7; ph++) begin
      write_reg(rptg_pkg::REG_RADAR_WIDTH, phase_cfg[ph][0]);
      write_reg(rptg_pkg::REG_TICKS_PER_SECOND, phase_cfg[ph][1]);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) send_event(random_event(), 1'b0);
    end
    in_if.valid <= 1'b0;
    wait (triangle_q.size() == 0);
    repeat (PIPE_DEPTH + 10) @(negedge clk);
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
